### hdl/lpps_pkg.sv
// shared types, constants and helper functions of the line position pid steering block
package lpps_pkg;

  // sensor row, allowed 2 to 8
  localparam int SENSOR_COUNT = 5;
  localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
  localparam int TOT_W        = $clog2(SENSOR_COUNT * (SENSOR_COUNT + 1) / 2 + 1);
  localparam int POS_SCALE    = 60;
  localparam int CENTRE_POS   = 180;
  localparam int POS_W        = $clog2(POS_SCALE * SENSOR_COUNT + 1);
  localparam int ERR_W        = POS_W + 1;
  localparam int DERR_W       = ERR_W + 1;
  localparam int SUM_W        = 32;

  localparam int GAIN_W  = 31;
  localparam int SPEED_W = 16;
  localparam int WHOLE_W = 8;
  localparam int DUTY_W  = 7;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;

  // power = acc / (60 * 2^16), done as shift then reciprocal
  localparam int POWER_SHIFT = 16;
  localparam int POWER_DIV   = POS_SCALE * (2 ** POWER_SHIFT);
  localparam int M_W         = $clog2(POWER_DIV);
  localparam int DIV_SHIFT   = 28;
  localparam int DIV_RECIP   = (2 ** DIV_SHIFT + POS_SCALE - 1) / POS_SCALE;
  localparam int DIV_PROD_W  = 45;

  // duty = x * 100 / 255 by reciprocal
  localparam int DUTY_SHIFT = 23;
  localparam int DUTY_RECIP = (2 ** DUTY_SHIFT + 254) / 255;
  localparam int DUTY_MUL   = 100 * DUTY_RECIP;
  localparam int DUTY_T_W   = DUTY_SHIFT + DUTY_W;

  // x / 7 for small x
  localparam int RECIP7_SHIFT = 16;
  localparam int RECIP7       = (2 ** RECIP7_SHIFT + 6) / 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 2'd0,
    CFG_GAIN_I    = 2'd1,
    CFG_GAIN_D    = 2'd2,
    CFG_TOP_SPEED = 2'd3
  } cfg_idx_t;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 31'd1497366528;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 31'd2517;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 31'd83886080;
  localparam logic [SPEED_W-1:0] TOP_SPEED_RST = 16'd45696;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] top_speed;
  } cfg_t;

  // one classified sample handed from front to back
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic signed [SUM_W-1:0]  sum;
  } pid_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_ACC,
    ST_ABS,
    ST_DIV,
    ST_FIN
  } back_state_t;

  typedef enum logic [1:0] {
    MSEL_NONE,
    MSEL_P,
    MSEL_D,
    MSEL_I
  } mul_sel_t;

  // 60 * total / count, count in 1..8
  function automatic logic [POS_W-1:0] mean_pos(input logic [TOT_W-1:0] tot,
                                                input logic [3:0] cnt);
    logic [31:0] tt;
    logic [31:0] t;
    logic [31:0] r;
    tt = 32'(tot);
    t  = tt * 32'(POS_SCALE);
    case (cnt)
      4'd1:    r = t;
      4'd2:    r = tt * 32'd30;
      4'd3:    r = tt * 32'd20;
      4'd4:    r = tt * 32'd15;
      4'd5:    r = tt * 32'd12;
      4'd6:    r = tt * 32'd10;
      4'd7:    r = (t * 32'(RECIP7)) >> RECIP7_SHIFT;
      4'd8:    r = t >> 3;
      default: r = 32'(CENTRE_POS);
    endcase
    return POS_W'(r);
  endfunction

  // trunc(x * 100 / 255)
  function automatic logic [DUTY_W-1:0] duty_of(input logic [WHOLE_W-1:0] x);
    logic [DUTY_T_W-1:0] t;
    t = DUTY_T_W'(x) * DUTY_T_W'(DUTY_MUL);
    return t[DUTY_SHIFT +: DUTY_W];
  endfunction

endpackage

### hdl/lpps_front.sv
// front end: takes sensor samples, finds line position and updates error state
module lpps_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpps_pkg::SENSOR_COUNT-1:0] in_sensor_bits,
  output logic                            push,
  output lpps_pkg::pid_item_t             push_item,
  input  logic                            q_full
);

  logic                                   f_valid_r, f_valid_nxt;
  logic [lpps_pkg::SENSOR_COUNT-1:0]      f_bits_r;
  logic [lpps_pkg::POS_W-1:0]             pos_r, pos_nxt;
  logic signed [lpps_pkg::ERR_W-1:0]      last_err_r;
  logic signed [lpps_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [lpps_pkg::CNT_W-1:0]             cnt;
  logic [lpps_pkg::TOT_W-1:0]             tot;
  logic signed [lpps_pkg::ERR_W-1:0]      err;
  logic signed [lpps_pkg::DERR_W-1:0]     derr;
  logic signed [lpps_pkg::SUM_W:0]        sum_ext;
  logic                                   accept;

  always_comb begin
    cnt = '0;
    tot = '0;
    for (int i = 0; i < lpps_pkg::SENSOR_COUNT; i++) begin
      if (f_bits_r[i]) begin
        cnt = cnt + lpps_pkg::CNT_W'(1);
        tot = tot + lpps_pkg::TOT_W'(i + 1);
      end
    end
  end

  always_comb begin
    // no sensor lit: position holds
    pos_nxt = (cnt != '0) ? lpps_pkg::mean_pos(tot, 4'(cnt)) : pos_r;
    err     = signed'({1'b0, pos_nxt}) - signed'(lpps_pkg::ERR_W'(lpps_pkg::CENTRE_POS));
    derr    = signed'({err[lpps_pkg::ERR_W-1], err})
            - signed'({last_err_r[lpps_pkg::ERR_W-1], last_err_r});
    sum_ext = signed'({sum_r[lpps_pkg::SUM_W-1], sum_r})
            + signed'({{(lpps_pkg::SUM_W + 1 - lpps_pkg::ERR_W){err[lpps_pkg::ERR_W-1]}}, err});
    if (sum_ext[lpps_pkg::SUM_W] != sum_ext[lpps_pkg::SUM_W-1]) begin
      sum_nxt = sum_ext[lpps_pkg::SUM_W] ? {1'b1, {(lpps_pkg::SUM_W-1){1'b0}}}
                                          : {1'b0, {(lpps_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_ext[lpps_pkg::SUM_W-1:0];
    end
  end

  assign push           = f_valid_r && !q_full;
  assign in_ready       = !f_valid_r || push;
  assign accept         = in_valid && in_ready;
  assign push_item.err  = err;
  assign push_item.derr = derr;
  assign push_item.sum  = sum_nxt;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r  <= 1'b0;
      pos_r      <= lpps_pkg::POS_W'(lpps_pkg::CENTRE_POS);
      last_err_r <= '0;
      sum_r      <= '0;
    end else begin
      f_valid_r <= f_valid_nxt;
      if (push) begin
        pos_r      <= pos_nxt;
        last_err_r <= err;
        sum_r      <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_bits_r <= in_sensor_bits;
    end
  end

endmodule

### hdl/lpps_queue.sv
// small fifo of classified items between front and back
module lpps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpps_pkg::pid_item_t wdata,
  input  logic                pop,
  output lpps_pkg::pid_item_t rdata,
  output logic                full,
  output logic                empty
);

  lpps_pkg::pid_item_t              mem_r [lpps_pkg::QUEUE_DEPTH];
  logic [lpps_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lpps_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lpps_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full    = (cnt_r == lpps_pkg::QCNT_W'(lpps_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lpps_pkg::QPTR_W'(lpps_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + lpps_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lpps_pkg::QPTR_W'(lpps_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + lpps_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + lpps_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - lpps_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/lpps_back.sv
// back end: pid sum on one shared multiplier, scaling, clamp and wheel duties
module lpps_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpps_pkg::cfg_t               cfg,
  input  logic                         q_empty,
  input  lpps_pkg::pid_item_t          q_item,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lpps_pkg::DUTY_W-1:0]  out_left_duty,
  output logic [lpps_pkg::DUTY_W-1:0]  out_right_duty,
  output logic                         out_turn_left
);

  lpps_pkg::back_state_t                state_r, state_nxt;
  lpps_pkg::mul_sel_t                   mul_sel;
  logic                                 prod_en, acc_clr, acc_add, abs_en, div_en, out_load;

  lpps_pkg::pid_item_t                  item_r;
  logic signed [lpps_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic signed [lpps_pkg::PROD_W-1:0]   prod_nxt, prod_r;
  logic signed [lpps_pkg::ACC_W-1:0]    acc_r;
  logic [lpps_pkg::ACC_W-1:0]           mag;
  logic                                 neg_r, big_r;
  logic [lpps_pkg::M_W-1:0]             m_r;
  logic [lpps_pkg::DIV_PROD_W-1:0]      q_prod;
  logic [lpps_pkg::SPEED_W-1:0]         q_r, mag_c;
  logic                                 neg;
  logic [lpps_pkg::WHOLE_W-1:0]         inner, outer;
  logic [lpps_pkg::DUTY_W-1:0]          inner_duty, outer_duty;
  logic                                 out_valid_r;

  localparam logic [lpps_pkg::ACC_W-1:0] POWER_OVF =
    lpps_pkg::ACC_W'(lpps_pkg::POWER_DIV) << lpps_pkg::SPEED_W;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpps_pkg::ST_IDLE:  if (!q_empty) state_nxt = lpps_pkg::ST_MUL_P;
      lpps_pkg::ST_MUL_P: state_nxt = lpps_pkg::ST_MUL_D;
      lpps_pkg::ST_MUL_D: state_nxt = lpps_pkg::ST_MUL_I;
      lpps_pkg::ST_MUL_I: state_nxt = lpps_pkg::ST_ACC;
      lpps_pkg::ST_ACC:   state_nxt = lpps_pkg::ST_ABS;
      lpps_pkg::ST_ABS:   state_nxt = lpps_pkg::ST_DIV;
      lpps_pkg::ST_DIV:   state_nxt = lpps_pkg::ST_FIN;
      lpps_pkg::ST_FIN:   if (!out_valid_r || out_ready) state_nxt = lpps_pkg::ST_IDLE;
      default:            state_nxt = lpps_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    mul_sel  = lpps_pkg::MSEL_NONE;
    prod_en  = 1'b0;
    acc_clr  = 1'b0;
    acc_add  = 1'b0;
    abs_en   = 1'b0;
    div_en   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      lpps_pkg::ST_IDLE:  pop = !q_empty;
      lpps_pkg::ST_MUL_P: begin
        mul_sel = lpps_pkg::MSEL_P;
        prod_en = 1'b1;
        acc_clr = 1'b1;
      end
      lpps_pkg::ST_MUL_D: begin
        mul_sel = lpps_pkg::MSEL_D;
        prod_en = 1'b1;
        acc_add = 1'b1;
      end
      lpps_pkg::ST_MUL_I: begin
        mul_sel = lpps_pkg::MSEL_I;
        prod_en = 1'b1;
        acc_add = 1'b1;
      end
      lpps_pkg::ST_ACC:   acc_add = 1'b1;
      lpps_pkg::ST_ABS:   abs_en = 1'b1;
      lpps_pkg::ST_DIV:   div_en = 1'b1;
      lpps_pkg::ST_FIN:   out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (mul_sel)
      lpps_pkg::MSEL_P: begin
        mul_a = signed'({1'b0, cfg.gain_p});
        mul_b = signed'({{(lpps_pkg::MUL_W - lpps_pkg::ERR_W){item_r.err[lpps_pkg::ERR_W-1]}},
                         item_r.err});
      end
      lpps_pkg::MSEL_D: begin
        mul_a = signed'({1'b0, cfg.gain_d});
        mul_b = signed'({{(lpps_pkg::MUL_W - lpps_pkg::DERR_W){item_r.derr[lpps_pkg::DERR_W-1]}},
                         item_r.derr});
      end
      lpps_pkg::MSEL_I: begin
        mul_a = signed'({1'b0, cfg.gain_i});
        mul_b = item_r.sum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // magnitude of the sum, and the divide by 60 via reciprocal
  assign mag    = acc_r[lpps_pkg::ACC_W-1] ? lpps_pkg::ACC_W'(-acc_r) : lpps_pkg::ACC_W'(acc_r);
  assign q_prod = lpps_pkg::DIV_PROD_W'(m_r) * lpps_pkg::DIV_PROD_W'(lpps_pkg::DIV_RECIP);

  // clamp and wheel split
  always_comb begin
    mag_c      = (q_r > cfg.top_speed) ? cfg.top_speed : q_r;
    neg        = neg_r && (mag_c != '0);
    outer      = cfg.top_speed[lpps_pkg::SPEED_W-1 -: lpps_pkg::WHOLE_W];
    inner      = outer - mag_c[lpps_pkg::SPEED_W-1 -: lpps_pkg::WHOLE_W];
    inner_duty = lpps_pkg::duty_of(inner);
    outer_duty = lpps_pkg::duty_of(outer);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (prod_en) begin
      prod_r <= prod_nxt;
    end
    if (acc_clr) begin
      acc_r <= '0;
    end else if (acc_add) begin
      acc_r <= acc_r + signed'({{(lpps_pkg::ACC_W - lpps_pkg::PROD_W){prod_r[lpps_pkg::PROD_W-1]}},
                                prod_r});
    end
    if (abs_en) begin
      neg_r <= acc_r[lpps_pkg::ACC_W-1];
      big_r <= (mag >= POWER_OVF);
      m_r   <= mag[lpps_pkg::POWER_SHIFT +: lpps_pkg::M_W];
    end
    if (div_en) begin
      // beyond 16 bits the clamp wins anyway
      q_r <= big_r ? '1 : q_prod[lpps_pkg::DIV_SHIFT +: lpps_pkg::SPEED_W];
    end
    if (out_load) begin
      out_left_duty  <= neg ? inner_duty : outer_duty;
      out_right_duty <= neg ? outer_duty : inner_duty;
      out_turn_left  <= neg;
    end
  end

endmodule

### hdl/line_position_pid_steer.sv
// top level of the line position pid steering block with its configuration registers
//
// Each item is one line-sensor sample (bit i set when sensor i sees the line); each
// item gives exactly one result: left and right wheel duty in percent and a flag that
// says the left wheel is the slowed one. Line position is 60 times the mean weight of
// the lit sensors (sensor i weighs i+1) and holds when no sensor is lit; the error
// against the centre drives a pid sum with a saturating 32-bit integral. The front
// stage takes a sample per cycle while the queue has room, classifies it and
// updates the error state, then hands it to a two-entry queue. The back sequencer
// takes each item from the queue, runs the p, d and i products through a single
// shared 32x32 multiplier, then does a final accumulate, a magnitude step, a
// reciprocal divide and a clamp and duty step into the output register. It takes a
// new item only once it is through with the last one. The output register frees
// the back end as soon as its result is taken; while a result waits, the back end,
// the queue and the front register still take up to four more samples.
// Configuration registers are written on cfg_we with no wait.
module line_position_pid_steer (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lpps_pkg::SENSOR_COUNT-1:0] in_sensor_bits,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lpps_pkg::DUTY_W-1:0]       out_left_duty,
  output logic [lpps_pkg::DUTY_W-1:0]       out_right_duty,
  output logic                              out_turn_left,
  // register writes
  input  logic                              cfg_we,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpps_pkg::CFG_W-1:0]        cfg_data
);

  lpps_pkg::cfg_t       cfg_r;
  logic                 push;
  lpps_pkg::pid_item_t  push_item;
  logic                 q_full;
  logic                 q_empty;
  lpps_pkg::pid_item_t  q_item;
  logic                 pop;

  // configuration registers, reset to the nominal tuning
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= lpps_pkg::GAIN_P_RST;
      cfg_r.gain_i    <= lpps_pkg::GAIN_I_RST;
      cfg_r.gain_d    <= lpps_pkg::GAIN_D_RST;
      cfg_r.top_speed <= lpps_pkg::TOP_SPEED_RST;
    end else if (cfg_we) begin
      case (lpps_pkg::cfg_idx_t'(cfg_index))
        lpps_pkg::CFG_GAIN_P:    cfg_r.gain_p    <= cfg_data;
        lpps_pkg::CFG_GAIN_I:    cfg_r.gain_i    <= cfg_data;
        lpps_pkg::CFG_GAIN_D:    cfg_r.gain_d    <= cfg_data;
        lpps_pkg::CFG_TOP_SPEED: cfg_r.top_speed <= cfg_data[lpps_pkg::SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // position, error, derivative and integral state
  lpps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sensor_bits (in_sensor_bits),
    .push           (push),
    .push_item      (push_item),
    .q_full         (q_full)
  );

  // decouples sampling from the pid arithmetic
  lpps_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_item),
    .pop   (pop),
    .rdata (q_item),
    .full  (q_full),
    .empty (q_empty)
  );

  // pid arithmetic, clamp and duty scaling
  lpps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_duty  (out_left_duty),
    .out_right_duty (out_right_duty),
    .out_turn_left  (out_turn_left)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for line_position_pid_steer: directed table plus random sensor traffic
module testbench;

  localparam int NUM_SENSORS = lpps_pkg::SENSOR_COUNT;
  localparam int MID_POS = 180;                      // centre of the line for five sensors
  localparam int POS_STEP = 60;                      // position units per sensor weight
  localparam longint POWER_SCALE = 64'sd3932160;     // 60 * 2^16
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [lpps_pkg::GAIN_W-1:0] GAIN_MAX = 31'h7FFFFFFF;
  localparam logic [lpps_pkg::SPEED_W-1:0] SPEED_MAX = 16'd65280;

  // one steering result as it leaves the block
  typedef struct packed {
    logic [lpps_pkg::DUTY_W-1:0] left_duty;
    logic [lpps_pkg::DUTY_W-1:0] right_duty;
    logic                        turn;
  } steer_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // directed row: either a register write or a sensor sample; typed rows carry
  // their own expected result, the others are checked against the predictor
  typedef struct packed {
    row_kind_t                   kind;
    lpps_pkg::cfg_idx_t          reg_sel;
    logic [lpps_pkg::CFG_W-1:0]  value;
    logic [4:0]                  bits;
    logic                        typed;
    logic [lpps_pkg::DUTY_W-1:0] left_duty;
    logic [lpps_pkg::DUTY_W-1:0] right_duty;
    logic                        turn;
  } plan_row_t;

  localparam int PLAN_LEN = 33;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // straight after reset: centre and lost line both give zero power
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00100, 1'b1, 7'd69,  7'd69,  1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00000, 1'b1, 7'd69,  7'd69,  1'b0},
    // far edges, full row, lost line after a swing, pairs and split patterns
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00001, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b10000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b11111, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00011, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b11000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b10001, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b01110, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b01010, 1'b0, 7'd0,   7'd0,   1'b0},
    // zero top speed clamps everything to a standstill
    '{ROW_WRITE,  lpps_pkg::CFG_TOP_SPEED, 31'd0,          5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b10000, 1'b1, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00001, 1'b1, 7'd0,   7'd0,   1'b0},
    // zero gains at full speed: both wheels at 100 percent
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_I,    31'd0,          5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_D,    31'd0,          5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_TOP_SPEED, 31'd65280,      5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b10000, 1'b1, 7'd100, 7'd100, 1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00001, 1'b1, 7'd100, 7'd100, 1'b0},
    // largest gains drive power into the clamp both ways
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_P,    31'h7FFFFFFF,   5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_I,    31'h7FFFFFFF,   5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_D,    31'h7FFFFFFF,   5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00001, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b10000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00100, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00110, 1'b0, 7'd0,   7'd0,   1'b0},
    // back to the power-up tuning
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_P,    31'd1497366528, 5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_I,    31'd2517,       5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_GAIN_D,    31'd83886080,   5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_WRITE,  lpps_pkg::CFG_TOP_SPEED, 31'd45696,      5'b00000, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b01100, 1'b0, 7'd0,   7'd0,   1'b0},
    '{ROW_SAMPLE, lpps_pkg::CFG_GAIN_P,    31'd0,          5'b00000, 1'b0, 7'd0,   7'd0,   1'b0}
  };

  // dut signals, all inputs known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [NUM_SENSORS-1:0] in_sensor_bits = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [lpps_pkg::DUTY_W-1:0] out_left_duty;
  logic [lpps_pkg::DUTY_W-1:0] out_right_duty;
  logic out_turn_left;
  logic cfg_we = 1'b0;
  lpps_pkg::cfg_idx_t cfg_index = lpps_pkg::CFG_GAIN_P;
  logic [lpps_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor copy of the steering state and tuning registers
  int unsigned line_pos = MID_POS;
  int prev_err = 0;
  int err_total = 0;
  logic [lpps_pkg::GAIN_W-1:0] kp = 31'd1497366528;
  logic [lpps_pkg::GAIN_W-1:0] ki = 31'd2517;
  logic [lpps_pkg::GAIN_W-1:0] kd = 31'd83886080;
  logic [lpps_pkg::SPEED_W-1:0] speed_cap = 16'd45696;

  steer_t steer_due[$];          // results still owed by the block, oldest first
  int mismatches = 0;
  int cycle_count = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  int unsigned rx_cycle = 0;

  line_position_pid_steer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sensor_bits (in_sensor_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_duty  (out_left_duty),
    .out_right_duty (out_right_duty),
    .out_turn_left  (out_turn_left),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // steering law for one sample, advancing the position, last error and error sum
  function automatic steer_t predict_steer(input logic [NUM_SENSORS-1:0] bits);
    int unsigned lit, weight, mag, inner, outer;
    int k, e, de;
    longint s, acc, pw, cap;
    steer_t r;
    lit = 0;
    weight = 0;
    for (k = 0; k < NUM_SENSORS; k++) begin
      if (bits[k]) begin
        lit++;
        weight += k + 1;
      end
    end
    // lost line keeps the old position
    if (lit != 0) line_pos = weight * POS_STEP / lit;
    e = int'(line_pos) - MID_POS;
    de = e - prev_err;
    prev_err = e;
    // integral saturates at the signed 32-bit limits
    s = longint'(err_total) + e;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    else if (s < -64'sd2147483648) s = -64'sd2147483648;
    err_total = int'(s);
    acc = longint'(kp) * e + longint'(kd) * de + longint'(ki) * err_total;
    pw = acc / POWER_SCALE;                          // truncates toward zero
    cap = longint'(speed_cap);
    if (pw > cap) pw = cap;
    if (pw < -cap) pw = -cap;
    mag = int'(((pw < 0) ? -pw : pw) / 256);
    inner = (32'(speed_cap) - mag * 256) >> 8;
    outer = 32'(speed_cap) >> 8;
    // zero power counts as a right turn, both wheels then equal
    r.turn = (pw < 0);
    r.left_duty = lpps_pkg::DUTY_W'((((pw < 0) ? inner : outer) * 100) / 255);
    r.right_duty = lpps_pkg::DUTY_W'((((pw < 0) ? outer : inner) * 100) / 255);
    return r;
  endfunction

  function automatic logic [lpps_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return GAIN_MAX;
      2, 3: return lpps_pkg::GAIN_W'($urandom);
      default: return lpps_pkg::GAIN_W'($urandom >> $urandom_range(4, 14));  // usable tuning range
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
               what, got, want, cycle_count);
    mismatches++;
  endtask

  // register write while the block is idle; the predictor follows at once
  task automatic write_reg(input lpps_pkg::cfg_idx_t sel,
                           input logic [lpps_pkg::CFG_W-1:0] value);
    case (sel)
      lpps_pkg::CFG_GAIN_P:    kp = value[lpps_pkg::GAIN_W-1:0];
      lpps_pkg::CFG_GAIN_I:    ki = value[lpps_pkg::GAIN_W-1:0];
      lpps_pkg::CFG_GAIN_D:    kd = value[lpps_pkg::GAIN_W-1:0];
      lpps_pkg::CFG_TOP_SPEED: speed_cap = value[lpps_pkg::SPEED_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // hold the sender off until every owed result has come back, then wait a little more
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (steer_due.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  // offer one sample and hold it until taken; the result owed is logged on acceptance
  task automatic send_sample(input logic [NUM_SENSORS-1:0] bits, input logic typed,
                             input steer_t fixed);
    steer_t pred;
    in_valid <= 1'b1;
    in_sensor_bits <= bits;
    do @(posedge clk); while (!in_ready);
    pred = predict_steer(bits);
    steer_due.push_back(typed ? fixed : pred);
    @(negedge clk);
  endtask

  // result side: stall pattern of its own, reshuffled while the test runs
  always @(negedge clk) begin
    if (rx_cycle % 300 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat = 16'hFFFF;                                  // no stalls
        1: ready_pat = 16'($urandom) | 16'h0001;
        2: ready_pat = 16'h0001 << $urandom_range(0, 15);         // one slot in sixteen
        default: ready_pat = 16'($urandom & $urandom) | 16'h8000;
      endcase
    end
    out_ready <= ready_pat[rx_cycle % 16];
    rx_cycle++;
  end

  // compare each taken result with the oldest one owed
  always @(posedge clk) begin : check_steer
    steer_t due;
    if (rst_n && out_valid && out_ready) begin
      if (steer_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, 0);
      end else begin
        due = steer_due.pop_front();
        if (out_left_duty !== due.left_duty)
          report_mismatch("left_duty", int'(out_left_duty), int'(due.left_duty));
        if (out_right_duty !== due.right_duty)
          report_mismatch("right_duty", int'(out_right_duty), int'(due.right_duty));
        if (out_turn_left !== due.turn)
          report_mismatch("turn_left", int'(out_turn_left), int'(due.turn));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_position_pid_steer test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int k, ph, n, burst_left, track;
    logic [NUM_SENSORS-1:0] bits;
    steer_t fixed;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, back to back on the sample side
    for (k = 0; k < PLAN_LEN; k++) begin
      if (PLAN[k].kind == ROW_WRITE) begin
        drain(SETTLE_CYCLES);
        write_reg(PLAN[k].reg_sel, PLAN[k].value);
      end else begin
        fixed = '{PLAN[k].left_duty, PLAN[k].right_duty, PLAN[k].turn};
        send_sample(NUM_SENSORS'(PLAN[k].bits), PLAN[k].typed, fixed);
      end
    end

    // random phases, each under its own tuning; phase 0 keeps the power-up values
    track = NUM_SENSORS - 1;
    burst_left = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain(SETTLE_CYCLES);
        write_reg(lpps_pkg::CFG_GAIN_P, pick_gain());
        write_reg(lpps_pkg::CFG_GAIN_I, pick_gain());
        write_reg(lpps_pkg::CFG_GAIN_D, pick_gain());
        case ($urandom_range(0, 3))
          0: write_reg(lpps_pkg::CFG_TOP_SPEED, '0);
          1: write_reg(lpps_pkg::CFG_TOP_SPEED, lpps_pkg::CFG_W'(SPEED_MAX));
          default: write_reg(lpps_pkg::CFG_TOP_SPEED,
                             lpps_pkg::CFG_W'($urandom_range(0, SPEED_MAX)));
        endcase
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // bursts with gaps, except one phase that streams with no idling
        if (ph != 2) begin
          if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
        end
        // now and then let everything drain before the next item
        if ($urandom_range(0, 99) == 0) drain(0);
        // mostly a line drifting across the row, some lost line and noise
        case ($urandom_range(0, 9))
          0: bits = '0;
          1, 2, 3: bits = NUM_SENSORS'($urandom);
          default: begin
            track += int'($urandom_range(0, 2)) - 1;
            if (track < 0) track = 0;
            if (track > 2 * NUM_SENSORS - 2) track = 2 * NUM_SENSORS - 2;
            // even steps sit on one sensor, odd steps straddle two
            bits = NUM_SENSORS'((1 << (track / 2)) | ((track % 2) ? (2 << (track / 2)) : 0));
          end
        endcase
        send_sample(bits, 1'b0, '0);
      end
    end

    drain(SETTLE_CYCLES);
    if (mismatches == 0)
      $display("line_position_pid_steer test passed");
    else
      $display("line_position_pid_steer test failed");
    $finish;
  end

endmodule
